>>> rtl/core/smi_pkg.sv
// smi_pkg: shared types and constants for the sorted multiset store
// used by smi_req_if, smi_rsp_if, smi_cell and sorted_multiset_insert_delete_top
package smi_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int RSP_COUNT_W = 5;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_DELETED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic                       enable;
      op_type                     op;
      logic                       full;
      logic signed [VALUE_W-1:0]  value;
   } cell_cmd_type;

endpackage

>>> rtl/core/smi_req_if.sv
// smi_req_if: request channel of the sorted multiset store
// depends on smi_pkg
interface smi_req_if;
   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic signed [smi_pkg::VALUE_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

>>> rtl/core/smi_rsp_if.sv
// smi_rsp_if: response channel of the sorted multiset store
// depends on smi_pkg
interface smi_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [smi_pkg::STATUS_W-1:0]           status;
   logic [smi_pkg::RSP_COUNT_W-1:0]        count;
   logic                                   head_valid;
   logic signed [smi_pkg::VALUE_W-1:0]     head_value;

   modport source (output valid, output status, output count, output head_valid,
                   output head_value, input ready);
   modport sink   (input valid, input status, input count, input head_valid,
                   input head_value, output ready);
endinterface

>>> rtl/core/sorted_multiset_insert_delete_top.sv
// sorted_multiset_insert_delete_top: sorted multiset store built as a row of cells
// depends on smi_pkg, smi_req_if, smi_rsp_if and smi_cell
//
// Keeps up to CAPACITY signed values in ascending order, duplicates allowed.
// Every cell compares its entry with the request value in the same cycle, so
// a request is taken on an edge where valid and ready are both high, its
// response is registered on that same edge, and a new request is taken every
// cycle as long as the response is being consumed. The compare in each cell
// plus the match OR across the row sets the cycle time. Insert into a full
// store returns full and changes nothing; delete of an absent value returns
// not found. No clearing pass is needed after reset.
module sorted_multiset_insert_delete_top (
   input  logic       clock,
   input  logic       reset,
   smi_req_if.sink    req_if,
   smi_rsp_if.source  rsp_if
);

   localparam int N = smi_pkg::CAPACITY;

   logic [smi_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   smi_pkg::status_type                status_ff, status_in;
   logic                               head_valid_ff, head_valid_in;
   logic signed [smi_pkg::VALUE_W-1:0] head_value_ff, head_value_in;

   logic                               accept;
   logic                               full;
   logic                               found;
   smi_pkg::cell_cmd_type              cmd;

   logic [N-1:0]                       ge;
   logic [N-1:0]                       match;
   logic signed [smi_pkg::VALUE_W-1:0] cell_value [N];
   logic signed [smi_pkg::VALUE_W-1:0] cell_next  [N];

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign full         = (count_ff == smi_pkg::COUNT_W'(N));
   assign found        = |match;

   assign cmd.enable = accept;
   assign cmd.op     = smi_pkg::op_type'(req_if.opcode);
   assign cmd.full   = full;
   assign cmd.value  = req_if.value;

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                               left_ge;
      logic signed [smi_pkg::VALUE_W-1:0] left_value;
      logic signed [smi_pkg::VALUE_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_ge    = 1'b0;
         assign left_value = cell_value[i];
      end else begin : g_inner
         assign left_ge    = ge[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == N - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      smi_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (smi_pkg::COUNT_W'(i) < count_ff),
         .is_tail     (smi_pkg::COUNT_W'(i) == count_ff),
         .found       (found),
         .left_ge     (left_ge),
         .left_value  (left_value),
         .right_value (right_value),
         .ge          (ge[i]),
         .match       (match[i]),
         .value_ff    (cell_value[i]),
         .value_in    (cell_next[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      case (cmd.op)
         smi_pkg::OP_INSERT: begin
            if (full) begin
               status_in = smi_pkg::ST_FULL;
            end else begin
               status_in = smi_pkg::ST_INSERTED;
               count_in  = count_ff + smi_pkg::COUNT_W'(1);
            end
         end
         smi_pkg::OP_DELETE: begin
            if (found) begin
               status_in = smi_pkg::ST_DELETED;
               count_in  = count_ff - smi_pkg::COUNT_W'(1);
            end else begin
               status_in = smi_pkg::ST_NOT_FOUND;
            end
         end
         default: status_in = status_ff;
      endcase
      if (!accept) begin
         count_in  = count_ff;
         status_in = status_ff;
      end
   end

   assign head_valid_in = accept ? (count_in != '0) : head_valid_ff;
   assign head_value_in = accept ? ((count_in != '0) ? cell_next[0] : '0) : head_value_ff;
   assign rsp_valid_in  = accept || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      head_valid_ff <= head_valid_in;
      head_value_ff <= head_value_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.count      = smi_pkg::RSP_COUNT_W'(count_ff);
   assign rsp_if.head_valid = head_valid_ff;
   assign rsp_if.head_value = head_value_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= smi_pkg::COUNT_W'(N))
      else $error("entry count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && cmd.op == smi_pkg::OP_INSERT && !full
      |=> count_ff == $past(count_ff) + smi_pkg::COUNT_W'(1) && status_ff == smi_pkg::ST_INSERTED)
      else $error("insert did not add an entry");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == smi_pkg::ST_FULL |-> count_ff == smi_pkg::COUNT_W'(N))
      else $error("full status with free entries");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> head_valid_ff == (count_ff != '0))
      else $error("head valid disagrees with count");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |=> $stable(count_ff) && rsp_valid_ff)
      else $error("state changed while response stalled");

   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      count_ff > smi_pkg::COUNT_W'(1) |-> cell_value[0] <= cell_value[1])
      else $error("first two entries out of order");

endmodule

>>> rtl/core/smi_cell.sv
// smi_cell: one entry of the sorted row, compares against the broadcast value
// and shifts toward either neighbor; depends on smi_pkg
module smi_cell (
   input  logic                               clock,
   input  smi_pkg::cell_cmd_type              cmd,
   input  logic                               occupied,
   input  logic                               is_tail,
   input  logic                               found,
   input  logic                               left_ge,
   input  logic signed [smi_pkg::VALUE_W-1:0] left_value,
   input  logic signed [smi_pkg::VALUE_W-1:0] right_value,
   output logic                               ge,
   output logic                               match,
   output logic signed [smi_pkg::VALUE_W-1:0] value_ff,
   output logic signed [smi_pkg::VALUE_W-1:0] value_in
);

   assign ge    = occupied && (value_ff >= cmd.value);
   assign match = occupied && (value_ff == cmd.value);

   always_comb begin
      value_in = value_ff;
      if (cmd.enable) begin
         case (cmd.op)
            smi_pkg::OP_INSERT: begin
               if (!cmd.full) begin
                  if (left_ge) begin
                     value_in = left_value;
                  end else if (ge || is_tail) begin
                     value_in = cmd.value;
                  end
               end
            end
            smi_pkg::OP_DELETE: begin
               if (found && ge) begin
                  value_in = right_value;
               end
            end
            default: value_in = value_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

>>> tb/sv/tb.sv
// tb: self-checking testbench for sorted_multiset_insert_delete_top, with random stalls
// on both channels and a scoreboard class that tracks the sorted store contents
// depends on smi_pkg, smi_req_if, smi_rsp_if and the block itself
module tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 250;

   typedef struct {
      smi_pkg::status_type                status;
      logic [smi_pkg::RSP_COUNT_W-1:0]    count;
      logic                               head_valid;
      logic signed [smi_pkg::VALUE_W-1:0] head_value;
   } store_outcome_type;

   class multiset_tracker_type;
      logic signed [smi_pkg::VALUE_W-1:0] entries [smi_pkg::CAPACITY];
      int unsigned                        n_stored;
      store_outcome_type                  pending_outcomes [$];
      int                                 mismatches;

      function new();
         n_stored   = 0;
         mismatches = 0;
      endfunction

      function void note_request(smi_pkg::op_type op, logic signed [smi_pkg::VALUE_W-1:0] v);
         int unsigned       pos;
         int unsigned       i;
         store_outcome_type o;
         pos = 0;
         if (op == smi_pkg::OP_INSERT) begin
            if (n_stored >= smi_pkg::CAPACITY) begin
               o.status = smi_pkg::ST_FULL;
            end else begin
               while (pos < n_stored && entries[pos] < v) pos++;
               for (i = n_stored; i > pos; i--) entries[i] = entries[i-1];
               entries[pos] = v;
               n_stored++;
               o.status = smi_pkg::ST_INSERTED;
            end
         end else begin
            while (pos < n_stored && entries[pos] != v) pos++;
            if (pos >= n_stored) begin
               o.status = smi_pkg::ST_NOT_FOUND;
            end else begin
               for (i = pos; i + 1 < n_stored; i++) entries[i] = entries[i+1];
               n_stored--;
               o.status = smi_pkg::ST_DELETED;
            end
         end
         o.count      = smi_pkg::RSP_COUNT_W'(n_stored);
         o.head_valid = (n_stored != 0);
         o.head_value = (n_stored != 0) ? entries[0] : '0;
         pending_outcomes.push_back(o);
      endfunction

      function logic signed [smi_pkg::VALUE_W-1:0] pick_stored();
         if (n_stored == 0) return $urandom();
         return entries[$urandom_range(n_stored - 1)];
      endfunction

      task report_mismatch(string what);
         $display("tb: mismatch: %s", what);
         mismatches++;
      endtask

      task check_response(logic [smi_pkg::STATUS_W-1:0] st,
                          logic [smi_pkg::RSP_COUNT_W-1:0] cnt,
                          logic hv, logic signed [smi_pkg::VALUE_W-1:0] hval);
         store_outcome_type o;
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected response status %0d count %0d", st, cnt));
            return;
         end
         o = pending_outcomes.pop_front();
         if (st !== o.status)
            report_mismatch($sformatf("status %0d, want %0d", st, o.status));
         if (cnt !== o.count)
            report_mismatch($sformatf("count %0d, want %0d", cnt, o.count));
         if (hv !== o.head_valid)
            report_mismatch($sformatf("head_valid %0b, want %0b", hv, o.head_valid));
         if (hval !== o.head_value)
            report_mismatch($sformatf("head_value %0d, want %0d", hval, o.head_value));
      endtask
   endclass

   logic clock;
   logic reset;
   int   send_idle;
   int   recv_stall;
   int   cycle_count;

   multiset_tracker_type tracker;

   smi_req_if req_ch ();
   smi_rsp_if rsp_ch ();

   sorted_multiset_insert_delete_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_response(rsp_ch.status, rsp_ch.count, rsp_ch.head_valid,
                                   rsp_ch.head_value);
         if (req_ch.valid && req_ch.ready)
            tracker.note_request(smi_pkg::op_type'(req_ch.opcode), req_ch.value);
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
   end

   // called at a falling edge, returns at the falling edge after the request is taken
   task automatic send_request(smi_pkg::op_type op, logic signed [smi_pkg::VALUE_W-1:0] v);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.value  <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (tracker.pending_outcomes.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [smi_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(9))
         0, 1, 2, 3: return int'($urandom_range(15)) - 8;
         4: begin
            case ($urandom_range(3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sh0000_0000;
               default: return 32'shffff_ffff;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic random_request(int insert_pct);
      if ($urandom_range(99) < insert_pct)
         send_request(smi_pkg::OP_INSERT, random_value());
      else if ($urandom_range(3) != 0)
         send_request(smi_pkg::OP_DELETE, tracker.pick_stored());
      else
         send_request(smi_pkg::OP_DELETE, random_value());
   endtask

   task automatic run_phase(int idle_pct, int stall_pct);
      int insert_pct;
      send_idle  = idle_pct;
      recv_stall = stall_pct;
      insert_pct = 50;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         // shift the insert/delete mix so the count sweeps between empty and full
         if (i % 40 == 0) begin
            case ($urandom_range(3))
               0: insert_pct = 20;
               1: insert_pct = 50;
               2: insert_pct = 70;
               default: insert_pct = 90;
            endcase
         end
         random_request(insert_pct);
      end
      wait_drained();
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.opcode = smi_pkg::OP_INSERT;
      req_ch.value  = '0;
      rsp_ch.ready  = 1'b0;
      send_idle     = 0;
      recv_stall    = 0;
      cycle_count   = 0;
      tracker       = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty delete, extremes, duplicates, absent value, full store
      send_request(smi_pkg::OP_DELETE, 32'sd5);
      send_request(smi_pkg::OP_INSERT, 32'sh7fff_ffff);
      send_request(smi_pkg::OP_INSERT, 32'sh8000_0000);
      send_request(smi_pkg::OP_INSERT, 32'sd0);
      send_request(smi_pkg::OP_INSERT, 32'sd0);
      send_request(smi_pkg::OP_INSERT, -32'sd1);
      send_request(smi_pkg::OP_DELETE, 32'sd0);
      send_request(smi_pkg::OP_DELETE, 32'sd12345);
      for (int i = 0; i < 12; i++)
         send_request(smi_pkg::OP_INSERT, (i % 4) * 1000 - 1500);
      send_request(smi_pkg::OP_INSERT, 32'sd77);
      send_request(smi_pkg::OP_DELETE, 32'sh8000_0000);
      send_request(smi_pkg::OP_DELETE, 32'sh7fff_ffff);
      wait_drained();

      run_phase(0, 0);
      run_phase(80, 0);
      run_phase(0, 80);
      run_phase(18, 18);

      repeat (8) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.pending_outcomes.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
